>>> hw/rtl/i2cms_pkg.sv
// Shared types, constants and phase helpers for the I2C master bit sequencer.
`default_nettype none

package i2cms_pkg;

	typedef enum logic [2:0] {
		CMD_IDLE        = 3'd0,
		CMD_START       = 3'd1,
		CMD_STOP        = 3'd2,
		CMD_WRITE       = 3'd3,
		CMD_READ        = 3'd4,
		CMD_READ_ACK    = 3'd5,
		CMD_WRITE_ACK   = 3'd6,
		CMD_START_WRITE = 3'd7
	} cmd_t;

	typedef struct packed {
		logic scl;
		logic sda;
	} pins_t;

	localparam logic [7:0] PHASE_TICKS_RST = 8'd11;
	localparam logic [1:0] ADDR_PHASE_TICKS = 2'd0;
	localparam logic [4:0] START_PHASES = 5'd3;

	function automatic logic [4:0] phase_total(input cmd_t cmd);
		logic [4:0] n;
		case (cmd)
			CMD_START, CMD_STOP:          n = 5'd3;
			CMD_WRITE, CMD_READ:          n = 5'd24;
			CMD_READ_ACK, CMD_WRITE_ACK:  n = 5'd2;
			CMD_START_WRITE:              n = 5'd27;
			default:                      n = 5'd0;
		endcase
		return n;
	endfunction

	// x / 3 for x < 32 via multiply by 11/32
	function automatic logic [3:0] div3(input logic [4:0] x);
		logic [8:0] prod;
		prod = {4'd0, x} * 9'd11;
		return prod[8:5];
	endfunction

	function automatic logic [1:0] mod3(input logic [4:0] x);
		logic [3:0] d;
		logic [4:0] r;
		d = div3(x);
		r = x - {d, 1'b0} - {1'b0, d};
		return r[1:0];
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/i2c_master_bit_sequencer_core.sv
// Top level of the tick-driven I2C master bit sequencer.
// The result of an accepted tick is registered; in_ready stays high while it is taken.
// Throughput: one tick transaction per cycle unless a result waits with out_ready low.
// A command of n phases spans n * phase_ticks accepted ticks (phase_ticks 0 acts as 1).
// Reset (arst_n low, asynchronous): idle, both lines released, phase_ticks = 11,
// rx_byte = 0, ack_seen = 1, no result pending.
`default_nettype none

module i2c_master_bit_sequencer_core import i2cms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [7:0]  tx_byte,
	input  logic        ack_to_send,
	input  logic        sda_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_level,
	output logic        sda_drive,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  rx_byte,
	output logic        ack_seen
);

	logic [7:0] phase_ticks_q;
	cmd_t       cmd_q;
	logic [4:0] ph_q;
	logic [7:0] tk_q;
	logic [7:0] sh_q;
	logic [7:0] rx_q;
	logic       ack_q;
	pins_t      pins_q;
	logic       done_q;
	logic       out_valid_q;

	cmd_t       cmd_d;
	logic [4:0] ph_d;
	logic [7:0] tk_d;
	logic [7:0] sh_d;
	logic [7:0] rx_d;
	logic       ack_d;
	pins_t      pins_d;
	logic       done_d;

	cmd_t       mode_cmd;
	logic       start;
	cmd_t       cmd0;
	logic [4:0] ph0;
	logic [4:0] ph_inc;
	logic [7:0] tk0;
	logic [7:0] tk1;
	logic [7:0] sh0;
	logic [7:0] sh1;
	logic [7:0] limit;
	pins_t      pins0;
	pins_t      pins_a;
	pins_t      pins_b;
	logic       accept;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign prdata = {24'd0, phase_ticks_q};
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_PHASE_TICKS);

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign mode_cmd = cmd_t'(mode);
	assign start    = (cmd_q == CMD_IDLE) && (mode_cmd != CMD_IDLE);
	assign limit    = (phase_ticks_q == 8'd0) ? 8'd1 : phase_ticks_q;

	always_comb begin
		sh0 = sh_q;
		if (start) begin
			case (mode_cmd)
				CMD_WRITE, CMD_START_WRITE: sh0 = tx_byte;
				CMD_READ:                   sh0 = 8'd0;
				CMD_WRITE_ACK:              sh0 = {7'd0, ack_to_send};
				default:                    sh0 = sh_q;
			endcase
		end
	end

	i2cms_pins u_first (
		.cmd      (mode_cmd),
		.phase    (5'd0),
		.shift    (sh0),
		.pins_in  (pins_q),
		.pins_out (pins_a)
	);

	assign cmd0   = start ? mode_cmd : cmd_q;
	assign ph0    = start ? 5'd0 : ph_q;
	assign tk0    = start ? 8'd0 : tk_q;
	assign pins0  = start ? pins_a : pins_q;
	assign tk1    = tk0 + 8'd1;
	assign ph_inc = ph0 + 5'd1;

	always_comb begin
		sh1 = sh0;
		if (cmd0 == CMD_READ && mod3(ph0) == 2'd1) begin
			sh1 = {sh0[6:0], sda_level};
		end
	end

	i2cms_pins u_next (
		.cmd      (cmd0),
		.phase    (ph_inc),
		.shift    (sh1),
		.pins_in  (pins0),
		.pins_out (pins_b)
	);

	always_comb begin
		cmd_d  = cmd0;
		ph_d   = ph0;
		tk_d   = tk0;
		sh_d   = sh0;
		rx_d   = rx_q;
		ack_d  = ack_q;
		pins_d = pins0;
		done_d = 1'b0;
		if (cmd0 != CMD_IDLE) begin
			tk_d = tk1;
			if (tk1 >= limit) begin
				tk_d = 8'd0;
				sh_d = sh1;
				if (cmd0 == CMD_READ_ACK && ph0 == 5'd1) begin
					ack_d = sda_level;
				end
				if (ph_inc >= phase_total(cmd0)) begin
					if (cmd0 == CMD_READ) begin
						rx_d = sh1;
					end
					cmd_d  = CMD_IDLE;
					ph_d   = 5'd0;
					done_d = 1'b1;
				end else begin
					ph_d   = ph_inc;
					pins_d = pins_b;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (cfg_wr) begin
			phase_ticks_q <= pwdata[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= CMD_IDLE;
			ph_q        <= 5'd0;
			tk_q        <= 8'd0;
			sh_q        <= 8'd0;
			rx_q        <= 8'd0;
			ack_q       <= 1'b1;
			pins_q      <= '{scl: 1'b1, sda: 1'b1};
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cmd_q  <= cmd_d;
				ph_q   <= ph_d;
				tk_q   <= tk_d;
				sh_q   <= sh_d;
				rx_q   <= rx_d;
				ack_q  <= ack_d;
				pins_q <= pins_d;
				done_q <= done_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = pins_q.scl;
	assign sda_drive = pins_q.sda;
	assign busy_res  = (cmd_q != CMD_IDLE);
	assign done_res  = done_q;
	assign rx_byte   = rx_q;
	assign ack_seen  = ack_q;

endmodule

`default_nettype wire

>>> hw/rtl/i2cms_pins.sv
// Pin levels set on entry to a command phase.
`default_nettype none

module i2cms_pins import i2cms_pkg::*; (
	input  cmd_t        cmd,
	input  logic [4:0]  phase,
	input  logic [7:0]  shift,
	input  pins_t       pins_in,
	output pins_t       pins_out
);

	cmd_t       eff_cmd;
	logic [4:0] eff_p;
	logic [1:0] q;
	logic [2:0] b;
	logic [3:0] d;

	always_comb begin
		eff_cmd = cmd;
		eff_p   = phase;
		if (cmd == CMD_START_WRITE) begin
			if (phase < START_PHASES) begin
				eff_cmd = CMD_START;
			end else begin
				eff_cmd = CMD_WRITE;
				eff_p   = phase - START_PHASES;
			end
		end
		q = mod3(eff_p);
		d = div3(eff_p);
		b = d[2:0];

		pins_out = pins_in;
		case (eff_cmd)
			CMD_START: begin
				if (eff_p == 5'd0) begin
					pins_out.scl = 1'b0;
					pins_out.sda = 1'b1;
				end else if (eff_p == 5'd1) begin
					pins_out.scl = 1'b1;
				end else begin
					pins_out.sda = 1'b0;
				end
			end
			CMD_STOP: begin
				if (eff_p == 5'd0) begin
					pins_out.scl = 1'b0;
					pins_out.sda = 1'b0;
				end else if (eff_p == 5'd1) begin
					pins_out.scl = 1'b1;
				end else begin
					pins_out.sda = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (q == 2'd0) begin
					pins_out.scl = 1'b0;
				end else if (q == 2'd1) begin
					pins_out.sda = shift[3'd7 - b];
				end else begin
					pins_out.scl = 1'b1;
				end
			end
			CMD_READ: begin
				if (q == 2'd0) begin
					pins_out.scl = 1'b0;
					pins_out.sda = 1'b1;
				end else if (q == 2'd1) begin
					pins_out.scl = 1'b1;
				end
			end
			CMD_READ_ACK: begin
				if (eff_p == 5'd0) begin
					pins_out.scl = 1'b0;
					pins_out.sda = 1'b1;
				end else begin
					pins_out.scl = 1'b1;
				end
			end
			CMD_WRITE_ACK: begin
				if (eff_p == 5'd0) begin
					pins_out.scl = 1'b0;
					pins_out.sda = shift[0];
				end else begin
					pins_out.scl = 1'b1;
				end
			end
			default: begin
				pins_out = pins_in;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/i2cms_checker.sv
// Port-level checker for the I2C master bit sequencer, bound to the top level.
`default_nettype none

module i2cms_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pready,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic busy_res,
	input wire logic done_res
);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done with busy still set");

	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted transaction produced no result");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with free output slot");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before taken");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.busy_res  (busy_res),
	.done_res  (done_res)
);

`default_nettype wire
